// File: rtl/esc_pkg.sv
// Shared types and constants for the raw environmental sensor compensation block.
package esc_pkg;

  localparam int CFG_DATA_W  = 48;
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TEMP_CAL   = 3'd0,
    REG_PRESS_LOW  = 3'd1,
    REG_PRESS_MID  = 3'd2,
    REG_PRESS_HIGH = 3'd3,
    REG_HUM_LOW    = 3'd4,
    REG_HUM_HIGH   = 3'd5
  } reg_index_t;

  localparam logic [19:0] SKIP20 = 20'h80000;
  localparam logic [15:0] SKIP16 = 16'h8000;

  localparam logic signed [33:0] T_FINE_OFFSET = 34'sd128000;
  localparam logic [20:0]        PRESS_BASE    = 21'd1048576;
  localparam logic signed [63:0] PRESS_ONE_47  = 64'sh0000_8000_0000_0000;
  localparam logic signed [12:0] PRESS_SCALE   = 13'sd3125;
  localparam logic signed [31:0] HUM_T_OFFSET  = 32'sd76800;
  localparam logic signed [31:0] HUM_ROUND_A   = 32'sd16384;
  localparam logic signed [31:0] HUM_C_BIAS    = 32'sd32768;
  localparam logic signed [31:0] HUM_G_BIAS    = 32'sd2097152;
  localparam logic signed [31:0] HUM_ROUND_E   = 32'sd8192;
  localparam logic signed [31:0] HUM_MAX       = 32'sd419430400;
  localparam logic signed [31:0] TEMP_ROUND    = 32'sd128;

  // Long division: quotient bits resolved per stage, and the stage count.
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = 64 / DIV_STEP;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic        [7:0]  h1;
    logic signed [15:0] h2;
    logic        [7:0]  h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } cal_t;

  typedef struct packed {
    logic               ok;
    logic        [19:0] ap;
    logic        [15:0] ah;
    logic signed [31:0] tfine;
    logic signed [31:0] temp;
  } q_entry_t;

  typedef struct packed {
    logic               ok;
    logic               dz;
    logic               neg;
    logic signed [31:0] temp;
    logic signed [31:0] ha;
    logic signed [31:0] he;
  } div_side_t;

endpackage

// File: rtl/esc_front.sv
// Front end: accepts raw readings, flags skip markers and compensates temperature.
module esc_front (
  input  logic            clk,
  input  logic            rst,
  input  esc_pkg::cal_t   cal,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [19:0]     raw_pressure,
  input  logic [19:0]     raw_temperature,
  input  logic [15:0]     raw_humidity,
  input  logic            q_full,
  output logic            q_push,
  output esc_pkg::q_entry_t q_data
);
  import esc_pkg::*;

  logic       adv;
  logic [4:0] v;

  logic [19:0] ap1, ap2, ap3, ap4, ap5;
  logic [15:0] ah1, ah2, ah3, ah4, ah5;
  logic        ok1, ok2, ok3, ok4, ok5;
  logic signed [17:0] da1;
  logic signed [16:0] d1;
  logic signed [31:0] m2_2, dd2, v1_3, m3_3, tf4, tf5, temp5;

  logic signed [17:0] da_c;
  logic signed [16:0] d_c;
  logic signed [33:0] m2_full, dd_full;
  logic signed [47:0] m3_full;
  logic signed [31:0] t5_sum;

  assign adv      = !v[4] || !q_full;
  assign in_stall = !adv;
  assign q_push   = v[4] && !q_full;

  assign da_c = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
  assign d_c  = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, cal.t1});

  assign m2_full = da1 * $signed(cal.t2);
  assign dd_full = d1 * d1;
  assign m3_full = (dd2 >>> 12) * $signed(cal.t3);
  assign t5_sum  = (tf4 <<< 2) + tf4 + TEMP_ROUND;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ap1  <= raw_pressure;
      ah1  <= raw_humidity;
      ok1  <= (raw_pressure != SKIP20) && (raw_temperature != SKIP20) &&
              (raw_humidity != SKIP16);
      da1  <= da_c;
      d1   <= d_c;

      ap2  <= ap1;  ah2 <= ah1;  ok2 <= ok1;
      m2_2 <= m2_full[31:0];
      dd2  <= dd_full[31:0];

      ap3  <= ap2;  ah3 <= ah2;  ok3 <= ok2;
      v1_3 <= m2_2 >>> 11;
      m3_3 <= m3_full[31:0];

      ap4  <= ap3;  ah4 <= ah3;  ok4 <= ok3;
      tf4  <= v1_3 + (m3_3 >>> 14);

      ap5  <= ap4;  ah5 <= ah4;  ok5 <= ok4;
      tf5  <= tf4;
      temp5 <= t5_sum >>> 8;
    end
  end

  assign q_data.ok    = ok5;
  assign q_data.ap    = ap5;
  assign q_data.ah    = ah5;
  assign q_data.tfine = tf5;
  assign q_data.temp  = temp5;

endmodule

// File: rtl/esc_queue.sv
// Short queue that decouples the front end from the pressure and humidity back end.
module esc_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  esc_pkg::q_entry_t wdata,
  input  logic              pop,
  output esc_pkg::q_entry_t rdata,
  output logic              full,
  output logic              empty
);
  import esc_pkg::*;

  localparam int AW = $clog2(DEPTH);

  q_entry_t        mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/esc_div.sv
// Pipelined unsigned long divider, 64-bit dividend by 31-bit divisor, with a side payload.
module esc_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [63:0]        num,
  input  logic [30:0]        den,
  input  esc_pkg::div_side_t in_side,
  output logic               out_valid,
  output logic [63:0]        quo,
  output esc_pkg::div_side_t out_side
);
  import esc_pkg::*;

  logic [63:0] q_r    [DIV_STAGES];
  logic [30:0] r_r    [DIV_STAGES];
  logic [30:0] d_r    [DIV_STAGES];
  div_side_t   side_r [DIV_STAGES];
  logic        vld    [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [63:0] q_in, q_nx;
    logic [30:0] r_in, d_in, r_nx;
    div_side_t   side_in;
    logic        v_in;

    if (s == 0) begin : g_first
      assign q_in    = num;
      assign r_in    = '0;
      assign d_in    = den;
      assign side_in = in_side;
      assign v_in    = in_valid;
    end else begin : g_next
      assign q_in    = q_r[s-1];
      assign r_in    = r_r[s-1];
      assign d_in    = d_r[s-1];
      assign side_in = side_r[s-1];
      assign v_in    = vld[s-1];
    end

    // The dividend shifts out of the top of q while quotient bits fill the bottom.
    always_comb begin
      logic [31:0] t;
      q_nx = q_in;
      r_nx = r_in;
      for (int k = 0; k < DIV_STEP; k++) begin
        t    = {r_nx, q_nx[63]};
        q_nx = {q_nx[62:0], 1'b0};
        if (t >= {1'b0, d_in}) begin
          t       = t - {1'b0, d_in};
          q_nx[0] = 1'b1;
        end
        r_nx = t[30:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s]    <= q_nx;
        r_r[s]    <= r_nx;
        d_r[s]    <= d_in;
        side_r[s] <= side_in;
      end
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign quo       = q_r[DIV_STAGES-1];
  assign out_side  = side_r[DIV_STAGES-1];

endmodule

// File: rtl/esc_back.sv
// Back end: pressure and humidity compensation pipeline and the output register.
module esc_back (
  input  logic              clk,
  input  logic              rst,
  input  esc_pkg::cal_t     cal,
  input  logic              q_empty,
  input  esc_pkg::q_entry_t q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       temp_centidegrees,
  output logic [31:0]       pressure_q24_8,
  output logic [16:0]       humidity_q22_10,
  output logic              reading_valid
);
  import esc_pkg::*;

  logic       adv;
  logic [6:0] bv;
  logic [4:0] pv;

  // Pre-divide stages.
  logic               ok1, ok2, ok3, ok4, ok5, ok6, ok7;
  logic signed [31:0] tp1, tp2, tp3, tp4, tp5, tp6, tp7;
  logic signed [33:0] w1_1;
  logic signed [31:0] hv1;
  logic [20:0]        pr0_1, pr0_2, pr0_3, pr0_4;
  logic [15:0]        ah1, ah2;
  logic signed [63:0] ww2;
  logic signed [49:0] m5_2, m2_2, m5_3, m2_3;
  logic signed [31:0] mh5_2, mh6_2, mh3_2;
  logic signed [63:0] m6_3, m3_3;
  logic signed [31:0] ha3, hb3, hc3, ha4, ha5, ha6, ha7;
  logic signed [63:0] w2_4, y4, z5, num0_5, num6;
  logic signed [31:0] bc4, g5, f6, e7;
  logic signed [30:0] den6;
  logic [63:0]        nmag7;
  logic [30:0]        dmag7;
  logic               neg7, dz7;

  logic signed [67:0] ww_full;
  logic signed [79:0] m6_full, m3_full;
  logic signed [43:0] mh5_full;
  logic signed [39:0] mh6_full;
  logic signed [40:0] mh3_full;
  logic signed [31:0] h4x, a_sum;
  logic signed [63:0] bc_full;
  logic signed [80:0] z_full;
  logic signed [76:0] num_full;
  logic signed [47:0] f_full;
  logic signed [63:0] w2_c, x1_c;
  logic signed [31:0] tf;

  // Divider interface.
  div_side_t  side_in, side_out;
  logic       dv;
  logic [63:0] quo;

  // Post-divide stages.
  logic               okp1, okp2, okp3, okp4, dzp1, dzp2, dzp3, dzp4;
  logic signed [31:0] tpp1, tpp2, tpp3, tpp4;
  logic signed [63:0] q1, q2, q3, q4;
  logic signed [31:0] hvv1, hvv2, hvv3, hs2, ht3;
  logic [63:0]        lolo2, sq3;
  logic [31:0]        lohi2;
  logic signed [63:0] m8_2, w2p3, w2p4, m9_4;
  logic [16:0]        hum4;

  logic signed [63:0] qs_c;
  logic [63:0]        lolo_c, lohi_full;
  logic signed [79:0] m8_full, m9_full;
  logic signed [63:0] hs_full;
  logic signed [40:0] ht_full;
  logic signed [63:0] hv_full;
  logic signed [31:0] r_c;
  logic [31:0]        rc_c;
  logic signed [63:0] pr_sum, pr_c;

  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && !q_empty;
  assign tf    = q_data.tfine;

  assign ww_full  = w1_1 * w1_1;
  assign mh5_full = $signed(cal.h5) * hv1;
  assign mh6_full = hv1 * $signed(cal.h6);
  assign mh3_full = hv1 * $signed({1'b0, cal.h3});

  assign m6_full = ww2 * $signed(cal.p6);
  assign m3_full = ww2 * $signed(cal.p3);
  assign h4x     = $signed({{20{cal.h4[11]}}, cal.h4});
  assign a_sum   = $signed({2'b00, ah2, 14'b0}) - (h4x <<< 20) - mh5_2 + HUM_ROUND_A;

  assign w2_c = m6_3 + ($signed({{14{m5_3[49]}}, m5_3}) <<< 17) +
                ($signed({{48{cal.p4[15]}}, cal.p4}) <<< 35);
  assign x1_c = (m3_3 >>> 8) + ($signed({{14{m2_3[49]}}, m2_3}) <<< 12);
  assign bc_full = hb3 * hc3;

  assign z_full   = y4 * $signed({1'b0, cal.p1});
  assign num_full = num0_5 * PRESS_SCALE;
  assign f_full   = g5 * $signed(cal.h2);

  always_ff @(posedge clk) begin
    if (rst) begin
      bv <= '0;
      pv <= '0;
    end else if (adv) begin
      bv <= {bv[5:0], !q_empty};
      pv <= {pv[3:0], dv};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok1   <= q_data.ok;
      tp1   <= q_data.temp;
      ah1   <= q_data.ah;
      w1_1  <= $signed({{2{tf[31]}}, tf}) - T_FINE_OFFSET;
      hv1   <= tf - HUM_T_OFFSET;
      pr0_1 <= PRESS_BASE - {1'b0, q_data.ap};

      ok2   <= ok1;  tp2 <= tp1;  ah2 <= ah1;  pr0_2 <= pr0_1;
      ww2   <= ww_full[63:0];
      m5_2  <= w1_1 * $signed(cal.p5);
      m2_2  <= w1_1 * $signed(cal.p2);
      mh5_2 <= mh5_full[31:0];
      mh6_2 <= mh6_full[31:0];
      mh3_2 <= mh3_full[31:0];

      ok3   <= ok2;  tp3 <= tp2;  pr0_3 <= pr0_2;
      m6_3  <= m6_full[63:0];
      m3_3  <= m3_full[63:0];
      m5_3  <= m5_2;
      m2_3  <= m2_2;
      ha3   <= a_sum >>> 15;
      hb3   <= mh6_2 >>> 10;
      hc3   <= (mh3_2 >>> 11) + HUM_C_BIAS;

      ok4   <= ok3;  tp4 <= tp3;  pr0_4 <= pr0_3;  ha4 <= ha3;
      w2_4  <= w2_c;
      y4    <= PRESS_ONE_47 + x1_c;
      bc4   <= bc_full[31:0];

      ok5    <= ok4;  tp5 <= tp4;  ha5 <= ha4;
      z5     <= z_full[63:0];
      num0_5 <= $signed({11'b0, pr0_4, 32'b0} >> 1) - w2_4;
      g5     <= (bc4 >>> 10) + HUM_G_BIAS;

      ok6   <= ok5;  tp6 <= tp5;  ha6 <= ha5;
      den6  <= z5[63:33];
      num6  <= num_full[63:0];
      f6    <= f_full[31:0];

      // Signed truncating division is done on magnitudes with the sign restored after.
      ok7   <= ok6;  tp7 <= tp6;  ha7 <= ha6;
      nmag7 <= num6[63] ? (~num6 + 64'd1) : num6;
      dmag7 <= den6[30] ? (~den6 + 31'd1) : den6;
      neg7  <= num6[63] ^ den6[30];
      dz7   <= (den6 == '0);
      e7    <= (f6 + HUM_ROUND_E) >>> 14;
    end
  end

  assign side_in.ok   = ok7;
  assign side_in.dz   = dz7;
  assign side_in.neg  = neg7;
  assign side_in.temp = tp7;
  assign side_in.ha   = ha7;
  assign side_in.he   = e7;

  esc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (bv[6]),
    .num      (nmag7),
    .den      (dmag7),
    .in_side  (side_in),
    .out_valid(dv),
    .quo      (quo),
    .out_side (side_out)
  );

  // The square of q >>> 13 modulo 2^64 is built from 32-bit partial products.
  assign qs_c      = q1 >>> 13;
  assign lolo_c    = qs_c[31:0] * qs_c[31:0];
  assign lohi_full = qs_c[31:0] * qs_c[63:32];
  assign m8_full   = q1 * $signed(cal.p8);
  assign hv_full   = side_out.ha * side_out.he;
  assign hs_full   = (hvv1 >>> 15) * (hvv1 >>> 15);
  assign ht_full   = (hs2 >>> 7) * $signed({1'b0, cal.h1});
  assign m9_full   = $signed(sq3) * $signed(cal.p9);
  assign r_c       = hvv3 - (ht3 >>> 4);
  assign rc_c      = r_c[31] ? 32'd0 : ((r_c > HUM_MAX) ? HUM_MAX : r_c);
  assign pr_sum    = q4 + (m9_4 >>> 25) + w2p4;
  assign pr_c      = (pr_sum >>> 8) + ($signed({{48{cal.p7[15]}}, cal.p7}) <<< 4);

  always_ff @(posedge clk) begin
    if (adv) begin
      okp1  <= side_out.ok;
      dzp1  <= side_out.dz;
      tpp1  <= side_out.temp;
      q1    <= side_out.neg ? $signed(~quo + 64'd1) : $signed(quo);
      hvv1  <= hv_full[31:0];

      okp2  <= okp1;  dzp2 <= dzp1;  tpp2 <= tpp1;  q2 <= q1;  hvv2 <= hvv1;
      lolo2 <= lolo_c;
      lohi2 <= lohi_full[31:0];
      m8_2  <= m8_full[63:0];
      hs2   <= hs_full[31:0];

      okp3  <= okp2;  dzp3 <= dzp2;  tpp3 <= tpp2;  q3 <= q2;  hvv3 <= hvv2;
      sq3   <= lolo2 + {lohi2[30:0], 33'b0};
      w2p3  <= m8_2 >>> 19;
      ht3   <= ht_full[31:0];

      okp4  <= okp3;  dzp4 <= dzp3;  tpp4 <= tpp3;  q4 <= q3;
      w2p4  <= w2p3;
      m9_4  <= m9_full[63:0];
      hum4  <= rc_c[28:12];

      reading_valid     <= okp4;
      temp_centidegrees <= okp4 ? tpp4 : 32'd0;
      pressure_q24_8    <= (okp4 && !dzp4) ? pr_c[31:0] : 32'd0;
      humidity_q22_10   <= okp4 ? hum4 : 17'd0;
    end
  end

  assign out_valid = pv[4];

endmodule

// File: rtl/env_sensor_raw_compensation_unit.sv
// Throughput: one transaction per cycle, unless a stall on either side holds the flow;
// the 16-stage long divider sets the depth.
// A four-entry queue between temperature front end and pressure/humidity back end
// lets the input keep accepting while the output is stalled, until the queue fills.
// Reset zeroes the pipeline valid flags (not reading_valid) and the calibration registers.
// The user must write them via the plain write port only while idle; the block does not check.
module env_sensor_raw_compensation_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [esc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [esc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [19:0]                     raw_pressure,
  input  logic [19:0]                     raw_temperature,
  input  logic [15:0]                     raw_humidity,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [31:0]                     temp_centidegrees,
  output logic [31:0]                     pressure_q24_8,
  output logic [16:0]                     humidity_q22_10,
  output logic                            reading_valid
);
  import esc_pkg::*;

  logic [47:0] temp_cal, press_low, press_mid, press_high;
  logic [31:0] hum_low, hum_high;
  cal_t        cal;
  q_entry_t    q_wdata, q_rdata;
  logic        q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal   <= '0;
      press_low  <= '0;
      press_mid  <= '0;
      press_high <= '0;
      hum_low    <= '0;
      hum_high   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TEMP_CAL:   temp_cal   <= cfg_data;
        REG_PRESS_LOW:  press_low  <= cfg_data;
        REG_PRESS_MID:  press_mid  <= cfg_data;
        REG_PRESS_HIGH: press_high <= cfg_data;
        REG_HUM_LOW:    hum_low    <= cfg_data[31:0];
        REG_HUM_HIGH:   hum_high   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign cal.t1 = temp_cal[15:0];
  assign cal.t2 = $signed(temp_cal[31:16]);
  assign cal.t3 = $signed(temp_cal[47:32]);
  assign cal.p1 = press_low[15:0];
  assign cal.p2 = $signed(press_low[31:16]);
  assign cal.p3 = $signed(press_low[47:32]);
  assign cal.p4 = $signed(press_mid[15:0]);
  assign cal.p5 = $signed(press_mid[31:16]);
  assign cal.p6 = $signed(press_mid[47:32]);
  assign cal.p7 = $signed(press_high[15:0]);
  assign cal.p8 = $signed(press_high[31:16]);
  assign cal.p9 = $signed(press_high[47:32]);
  assign cal.h1 = hum_low[7:0];
  assign cal.h2 = $signed(hum_low[23:8]);
  assign cal.h3 = hum_low[31:24];
  assign cal.h4 = $signed(hum_high[11:0]);
  assign cal.h5 = $signed(hum_high[23:12]);
  assign cal.h6 = $signed(hum_high[31:24]);

  esc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cal            (cal),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .raw_pressure   (raw_pressure),
    .raw_temperature(raw_temperature),
    .raw_humidity   (raw_humidity),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  esc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .full (q_full),
    .empty(q_empty)
  );

  esc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cal              (cal),
    .q_empty          (q_empty),
    .q_data           (q_rdata),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .temp_centidegrees(temp_centidegrees),
    .pressure_q24_8   (pressure_q24_8),
    .humidity_q22_10  (humidity_q22_10),
    .reading_valid    (reading_valid)
  );

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("queue written while full");

  a_skip_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !reading_valid) |->
      (temp_centidegrees == 32'd0 && pressure_q24_8 == 32'd0 && humidity_q22_10 == 17'd0))
    else $error("skipped reading carries nonzero fields");

  a_humidity_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (humidity_q22_10 <= 17'd102400))
    else $error("humidity above clamp limit");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

// File: dv/env_sensor_raw_compensation_unit_tb.sv
// Self-checking testbench for the raw environmental sensor compensation unit.
`timescale 1ns / 100ps

module env_sensor_raw_compensation_unit_tb;
  import esc_pkg::*;

  typedef struct packed {
    logic [19:0] rp;
    logic [19:0] rt;
    logic [15:0] rh;
  } reading_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] press;
    logic [16:0] hum;
    logic        ok;
  } comp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [19:0] raw_pressure = '0;
  logic [19:0] raw_temperature = '0;
  logic [15:0] raw_humidity = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] temp_centidegrees, pressure_q24_8;
  logic [16:0] humidity_q22_10;
  logic reading_valid;

  env_sensor_raw_compensation_unit DUT (.*);

  always #10 clk = ~clk;

  logic [47:0] cal_reg [6];
  reading_t pending_readings[$];
  comp_t expected_results[$];
  int send_idle_pct = 0, recv_stall_pct = 0;
  int hold_off = 0;
  int errors = 0;
  longint cycles = 0;

  function automatic logic [63:0] sgn(logic [63:0] v, int bits);
    logic [63:0] m;
    m = (64'd1 << bits) - 1;
    v = v & m;
    return (v ^ (64'd1 << (bits - 1))) - (64'd1 << (bits - 1));
  endfunction

  function automatic logic [63:0] sdiv(logic [63:0] n, logic [63:0] d);
    if (d == '1) return -n;
    return $signed(n) / $signed(d);
  endfunction

  function automatic comp_t compensate(reading_t r);
    comp_t o;
    logic signed [31:0] t1, t2, t3, v1, v2, d, tf, h1, h2, h3, h4, h5, h6, v, a, b, c, e;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, w1, w2, pr, q;
    o = '0;
    if (r.rp == SKIP20 || r.rt == SKIP20 || r.rh == SKIP16) return o;
    t1 = cal_reg[0][15:0];
    t2 = sgn(cal_reg[0][31:16], 16);
    t3 = sgn(cal_reg[0][47:32], 16);
    v1 = $signed((({12'd0, r.rt} >> 3) - (t1 << 1)) * t2) >>> 11;
    d = ({12'd0, r.rt} >> 4) - t1;
    v2 = (((d * d) >>> 12) * t3) >>> 14;
    tf = v1 + v2;
    o.temp = (tf * 5 + 128) >>> 8;
    p1 = cal_reg[1][15:0];
    p2 = sgn(cal_reg[1][31:16], 16);
    p3 = sgn(cal_reg[1][47:32], 16);
    p4 = sgn(cal_reg[2][15:0], 16);
    p5 = sgn(cal_reg[2][31:16], 16);
    p6 = sgn(cal_reg[2][47:32], 16);
    p7 = sgn(cal_reg[3][15:0], 16);
    p8 = sgn(cal_reg[3][31:16], 16);
    p9 = sgn(cal_reg[3][47:32], 16);
    w1 = 64'(tf) - 128000;
    w2 = w1 * w1 * p6;
    w2 = w2 + ((w1 * p5) << 17);
    w2 = w2 + (p4 << 35);
    w1 = ((w1 * w1 * p3) >>> 8) + ((w1 * p2) << 12);
    w1 = (((64'sd1 <<< 47) + w1) * p1) >>> 33;
    if (w1 == 0) pr = 0;
    else begin
      pr = 1048576 - 64'(r.rp);
      q = sdiv(((pr << 31) - w2) * 3125, w1);
      w1 = (p9 * (q >>> 13) * (q >>> 13)) >>> 25;
      w2 = (p8 * q) >>> 19;
      pr = ((q + w1 + w2) >>> 8) + (p7 << 4);
    end
    o.press = pr[31:0];
    h1 = cal_reg[4][7:0];
    h2 = sgn(cal_reg[4][23:8], 16);
    h3 = cal_reg[4][31:24];
    h4 = sgn(cal_reg[5][11:0], 12);
    h5 = sgn(cal_reg[5][23:12], 12);
    h6 = sgn(cal_reg[5][31:24], 8);
    v = tf - 76800;
    a = $signed(({16'd0, r.rh} << 14) - (h4 << 20) - h5 * v + 16384) >>> 15;
    b = (v * h6) >>> 10;
    c = ((v * h3) >>> 11) + 32768;
    e = ((((b * c) >>> 10) + 2097152) * h2 + 8192) >>> 14;
    v = a * e;
    v = v - (((((v >>> 15) * (v >>> 15)) >>> 7) * h1) >>> 4);
    if (v < 0) v = 0;
    if (v > 419430400) v = 419430400;
    o.hum = 17'(v >> 12);
    o.ok = 1'b1;
    return o;
  endfunction

  // Driver: present the head of the queue, pop it when the transaction completes.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(compensate(pending_readings.pop_front()));
      end
      if ((!in_valid || !in_stall) ) begin
        if (pending_readings.size() > (in_valid && !in_stall ? 0 : 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          raw_pressure <= pending_readings[0].rp;
          raw_temperature <= pending_readings[0].rt;
          raw_humidity <= pending_readings[0].rh;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down once per cycle.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // Monitor: compare each output transaction against the oldest expectation.
  always @(posedge clk) begin
    comp_t exp_r;
    cycles <= cycles + 1;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result");
          errors = errors + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (temp_centidegrees !== exp_r.temp) begin
            $error("temp_centidegrees exp %0d got %0d", $signed(exp_r.temp),
                   $signed(temp_centidegrees));
            errors = errors + 1;
          end
          if (pressure_q24_8 !== exp_r.press) begin
            $error("pressure_q24_8 exp %0d got %0d", exp_r.press, pressure_q24_8);
            errors = errors + 1;
          end
          if (humidity_q22_10 !== exp_r.hum) begin
            $error("humidity_q22_10 exp %0d got %0d", exp_r.hum, humidity_q22_10);
            errors = errors + 1;
          end
          if (reading_valid !== exp_r.ok) begin
            $error("reading_valid exp %0d got %0d", exp_r.ok, reading_valid);
            errors = errors + 1;
          end
        end
      end
      if (hold_off > 0) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("env_sensor_raw_compensation_unit_tb NOT OK");
      $finish;
    end
  end

  task automatic write_cal(reg_index_t idx, logic [47:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx <= REG_HUM_HIGH) begin
      cal_reg[idx] = (idx >= REG_HUM_LOW) ? {16'd0, val[31:0]} : val;
    end
  endtask

  task automatic drain_queue();
    while (pending_readings.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  // Calibration in the range of real parts, so that deep arithmetic is exercised.
  task automatic write_typical();
    write_cal(REG_TEMP_CAL, {16'($urandom_range(0, 100)), 16'($urandom_range(25000, 28000)),
                             16'($urandom_range(27000, 29000))});
    write_cal(REG_PRESS_LOW, {16'(-$urandom_range(0, 3000)), 16'(-$urandom_range(10000, 11000)),
                              16'($urandom_range(35000, 38000))});
    write_cal(REG_PRESS_MID, {16'(-$urandom_range(0, 100)), 16'($urandom_range(0, 200)),
                              16'($urandom_range(5000, 9000))});
    write_cal(REG_PRESS_HIGH, {16'($urandom_range(4000, 6000)), 16'(-$urandom_range(10000, 14000)),
                               16'($urandom_range(0, 100))});
    write_cal(REG_HUM_LOW, {8'd0, 8'($urandom_range(0, 30)), 16'($urandom_range(300, 400)),
                            8'($urandom_range(50, 100))});
    write_cal(REG_HUM_HIGH, {8'($urandom_range(20, 40)), 12'($urandom_range(0, 60)),
                             12'($urandom_range(200, 400))});
  endtask

  task automatic add_random(int n);
    reading_t r;
    repeat (n) begin
      r.rp = ($urandom_range(99) < 70) ? 20'($urandom_range(200000, 600000)) : 20'($urandom);
      r.rt = ($urandom_range(99) < 70) ? 20'($urandom_range(400000, 600000)) : 20'($urandom);
      r.rh = 16'($urandom);
      case ($urandom_range(40))
        0: r.rp = SKIP20;
        1: r.rt = SKIP20;
        2: r.rh = SKIP16;
        default: ;
      endcase
      pending_readings.push_back(r);
    end
  endtask

  initial begin
    for (int i = 0; i < 6; i++) cal_reg[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // All-zero calibration: zero divisor on every item.
    pending_readings.push_back('{20'h00000, 20'h00000, 16'h0000});
    pending_readings.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
    drain_queue();
    write_cal(REG_TEMP_CAL, '1);
    write_cal(REG_PRESS_LOW, '1);
    write_cal(REG_PRESS_MID, '1);
    write_cal(REG_PRESS_HIGH, '1);
    write_cal(REG_HUM_LOW, '1);
    write_cal(REG_HUM_HIGH, '1);
    write_cal(reg_index_t'(3'd6), '1);
    write_cal(reg_index_t'(3'd7), '1);
    pending_readings.push_back('{20'h00000, 20'h00000, 16'h0000});
    pending_readings.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
    pending_readings.push_back('{SKIP20, 20'h12345, 16'h1234});
    pending_readings.push_back('{20'h12345, SKIP20, 16'h1234});
    pending_readings.push_back('{20'h12345, 20'h12345, SKIP16});
    drain_queue();
    write_typical();
    pending_readings.push_back('{20'd415148, 20'd519888, 16'd27000});
    pending_readings.push_back('{20'd300000, 20'd500000, 16'h0000});
    pending_readings.push_back('{20'd300000, 20'd500000, 16'hFFFF});
    pending_readings.push_back('{20'h7FFFF, 20'h7FFFF, 16'h7FFF});
    pending_readings.push_back('{20'h80001, 20'h80001, 16'h8001});
    drain_queue();
    // Random phases with varying sender idling, receiver stalling and calibration.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 61; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 61; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      if (ph == 5) begin
        for (int i = 0; i < 6; i++) write_cal(reg_index_t'(i), rand48());
      end else if (ph == 7) begin
        for (int i = 0; i < 6; i++) write_cal(reg_index_t'(i), '0);
      end else begin
        write_typical();
      end
      if (ph == 0) hold_off = 300;
      add_random(165);
      drain_queue();
    end
    if (errors == 0) begin
      $display("env_sensor_raw_compensation_unit_tb OK");
    end else begin
      $display("env_sensor_raw_compensation_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
